// File: rtl/ray_sphere_closest_hit_defines.svh
// Assertion macros for the ray/sphere intersector RTL.
// Included by ray_sphere_closest_hit.sv, which checks its own pipeline control.
`ifndef RAY_SPHERE_CLOSEST_HIT_DEFINES_SVH
`define RAY_SPHERE_CLOSEST_HIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RSCH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RSCH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rsch_pkg.sv
// Shared widths, constants and types for the ray/sphere intersector.
// No dependencies.
`timescale 1ns / 1ps

package rsch_pkg;

    localparam int COORD_W       = 32;
    localparam int DIR_W         = 18;
    localparam int DIST_W        = 31;
    localparam int NORM_W        = 18;
    localparam int MAG_W         = 31;
    localparam int NORM_MAG_W    = 17;
    localparam int FRAC_BITS_DEF = 16;
    localparam int unsigned NORM_SAT = 131071;

    localparam int IN_FIELDS_W  = 9 * 32 + 3 * 18 + 2 * 31 - 96;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DIST_W + 3 * COORD_W + 3 * NORM_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] o;
        logic [2:0][DIR_W-1:0]   d;
        logic [2:0][COORD_W-1:0] c;
    } t_geom;

endpackage

// File: rtl/rsch_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a payload word alongside; depends on rsch_pkg for defaults.
`timescale 1ns / 1ps

module rsch_isqrt #(
    parameter int IN_W  = 64,
    parameter int PAY_W = rsch_pkg::COORD_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [IN_W-1:0]    i_rad,
    input  logic [PAY_W-1:0]   i_pay,
    output logic               o_valid,
    output logic [IN_W/2-1:0]  o_root,
    output logic [PAY_W-1:0]   o_pay
);
    import rsch_pkg::*;

    localparam int STAGES = IN_W / 2;

    wire [IN_W-1:0]  w_x   [0:STAGES];
    wire [IN_W-1:0]  w_r   [0:STAGES];
    wire             w_v   [0:STAGES];
    wire [PAY_W-1:0] w_pay [0:STAGES];

    assign w_x[0]   = i_rad;
    assign w_r[0]   = '0;
    assign w_v[0]   = i_valid;
    assign w_pay[0] = i_pay;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [IN_W:0] BIT = (IN_W + 1)'(1) << (IN_W - 2 - 2 * k);
        logic [IN_W:0]   n_try;
        logic            n_ge;
        logic [IN_W-1:0] r_x;
        logic [IN_W-1:0] r_r;
        logic            r_v;
        logic [PAY_W-1:0] r_pay;

        always_comb begin
            n_try = {1'b0, w_r[k]} + BIT;
            n_ge  = ({1'b0, w_x[k]} >= n_try);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x   <= n_ge ? (w_x[k] - n_try[IN_W-1:0]) : w_x[k];
                r_r   <= n_ge ? ((w_r[k] >> 1) + BIT[IN_W-1:0]) : (w_r[k] >> 1);
                r_pay <= w_pay[k];
            end
        end

        assign w_x[k+1]   = r_x;
        assign w_r[k+1]   = r_r;
        assign w_v[k+1]   = r_v;
        assign w_pay[k+1] = r_pay;
    end

    assign o_valid = w_v[STAGES];
    assign o_root  = w_r[STAGES][IN_W/2-1:0];
    assign o_pay   = w_pay[STAGES];

endmodule

// File: rtl/rsch_ndiv.sv
// Pipelined restoring divider for the three normal components, one
// quotient bit per stage. Depends on rsch_pkg.
`timescale 1ns / 1ps

module rsch_ndiv #(
    parameter int FRAC_BITS = rsch_pkg::FRAC_BITS_DEF,
    parameter int PAY_W     = rsch_pkg::COORD_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [2:0][rsch_pkg::MAG_W-1:0]   i_m,
    input  logic [rsch_pkg::COORD_W-1:0]      i_den,
    input  logic [PAY_W-1:0]                  i_pay,
    output logic                              o_valid,
    output logic [2:0][FRAC_BITS:0]           o_q,
    output logic [PAY_W-1:0]                  o_pay
);
    import rsch_pkg::*;

    localparam int STAGES = FRAC_BITS + 1;
    localparam int REM_W  = COORD_W + 1;

    wire [2:0][REM_W-1:0]     w_rem [0:STAGES];
    wire [2:0][FRAC_BITS:0]   w_q   [0:STAGES];
    wire [COORD_W-1:0]        w_den [0:STAGES];
    wire                      w_v   [0:STAGES];
    wire [PAY_W-1:0]          w_pay [0:STAGES];

    for (genvar l = 0; l < 3; l++) begin : g_in
        assign w_rem[0][l] = REM_W'(i_m[l]);
    end
    assign w_q[0]   = '0;
    assign w_den[0] = i_den;
    assign w_v[0]   = i_valid;
    assign w_pay[0] = i_pay;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [2:0][REM_W-1:0]   n_rin;
        logic [2:0]              n_ge;
        logic [2:0][REM_W-1:0]   r_rem;
        logic [2:0][FRAC_BITS:0] r_q;
        logic [COORD_W-1:0]      r_den;
        logic                    r_v;
        logic [PAY_W-1:0]        r_pay;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                n_rin[l] = (k == 0) ? w_rem[k][l] : {w_rem[k][l][REM_W-2:0], 1'b0};
                n_ge[l]  = (n_rin[l] >= {1'b0, w_den[k]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[l] <= n_ge[l] ? (n_rin[l] - {1'b0, w_den[k]}) : n_rin[l];
                    r_q[l]   <= {w_q[k][l][FRAC_BITS-1:0], n_ge[l]};
                end
                r_den <= w_den[k];
                r_pay <= w_pay[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_q[k+1]   = r_q;
        assign w_den[k+1] = r_den;
        assign w_v[k+1]   = r_v;
        assign w_pay[k+1] = r_pay;
    end

    assign o_valid = w_v[STAGES];
    assign o_q     = w_q[STAGES];
    assign o_pay   = w_pay[STAGES];

endmodule

// File: rtl/ray_sphere_closest_hit.sv
// Ray/sphere closest-hit test: front arithmetic, two root pipelines,
// normal divider and output skid. Depends on rsch_pkg, rsch_isqrt, rsch_ndiv and the defines header.
//
// Usage:
//   Input item on s_axis: ray origin, unit direction, sphere center,
//   radius squared and best distance so far (Q16.16 fixed point).
//   Result item on m_axis: new distance, hit point and unit normal in
//   tdata, the hit flag in tuser. Point and normal read zero on a miss.
//   The pipeline has six front stages, 32 stages of the discriminant
//   root, seven stages for the hit point and length, 32 stages of the
//   length root, FRAC_BITS + 1 divider stages and one output register.
//   Throughput, while s_axis_tready is high, is one item per cycle;
//   every stage is a register with a valid bit and all advance on one enable.
//   When the receiver stalls, the output register holds its item and
//   one more item lands in the skid register; s_axis_tready then drops
//   until the skid register empties. Nothing is lost or repeated.
//   Reset clears all valid bits; s_axis_tready is high right after.
`timescale 1ns / 1ps

module ray_sphere_closest_hit #(
    parameter int FRAC_BITS = rsch_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, sphere_center_x/y/z,
    // radius_squared, best_distance
    input  logic [rsch_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // new_distance, point_x/y/z, normal_x/y/z
    output logic [rsch_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // is_hit
    output logic [0:0]                         m_axis_tuser
);
    import rsch_pkg::*;
    `include "ray_sphere_closest_hit_defines.svh"

    localparam logic [NORM_MAG_W-1:0] DEG_Z =
        ((64'd1 << FRAC_BITS) > 64'(NORM_SAT)) ? NORM_MAG_W'(NORM_SAT)
                                               : NORM_MAG_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic               cand;
        logic [COORD_W-1:0] vu;
        t_geom              g;
        logic [DIST_W-1:0]  best;
    } t_sq1;

    typedef struct packed {
        logic                    hit;
        logic [DIST_W-1:0]       near_t;
        logic [2:0][COORD_W-1:0] pt;
        logic [2:0]              sgn;
        logic [2:0][MAG_W-1:0]   m;
    } t_sq2;

    typedef struct packed {
        logic                    hit;
        logic [DIST_W-1:0]       near_t;
        logic [2:0][COORD_W-1:0] pt;
        logic [2:0]              sgn;
        logic                    lz;
    } t_dvp;

    localparam int SQ1_W = $bits(t_sq1);
    localparam int SQ2_W = $bits(t_sq2);
    localparam int DVP_W = $bits(t_dvp);

    logic en;
    logic r_skd_v;
    assign en = !r_skd_v;
    assign s_axis_tready = en;

    // input unpack
    t_geom             w_g;
    logic [DIST_W-1:0] w_rsq;
    logic [DIST_W-1:0] w_best;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_g.o[i] = s_axis_tdata[32*i +: 32];
            w_g.d[i] = s_axis_tdata[96 + 18*i +: 18];
            w_g.c[i] = s_axis_tdata[150 + 32*i +: 32];
        end
        w_rsq  = s_axis_tdata[246 +: 31];
        w_best = s_axis_tdata[277 +: 31];
    end

    // stage registers
    logic                r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    t_geom               r_s1_g, r_s2_g, r_s3_g, r_s4_g, r_s5_g, r_s6_g;
    logic [DIST_W-1:0]   r_s1_rsq, r_s2_rsq, r_s3_rsq, r_s4_rsq;
    logic [DIST_W-1:0]   r_s1_best, r_s2_best, r_s3_best, r_s4_best, r_s5_best, r_s6_best;
    logic [COORD_W:0]    r_s1_e [3];
    logic signed [50:0]  r_s2_prod [3];
    logic [63:0]         r_s2_sq [3];
    logic signed [52:0]  r_s3_proj;
    logic [63:0]         r_s3_eo, r_s4_eo;
    logic                r_s4_vok, r_s5_vok;
    logic [COORD_W-1:0]  r_s4_vu, r_s5_vu, r_s6_vu;
    logic [63:0]         r_s4_v2, r_s5_v2;
    logic [65:0]         r_s5_disc;
    logic [63:0]         r_s6_x;
    logic                r_s6_cand;

    logic [COORD_W:0]    n_s1_e [3];
    logic [COORD_W:0]    n_s2_neg [3];
    logic [COORD_W-1:0]  n_s2_mag [3];
    logic signed [52:0]  n_s3_vraw;
    logic [63:0]         n_s3_eo;
    logic [65:0]         n_s5_disc;
    logic [63:0]         n_s6_x;
    logic                n_s6_cand;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_e[i]   = {w_g.c[i][COORD_W-1], w_g.c[i]} - {w_g.o[i][COORD_W-1], w_g.o[i]};
            n_s2_neg[i] = (COORD_W + 1)'(0) - r_s1_e[i];
            n_s2_mag[i] = r_s1_e[i][COORD_W] ? n_s2_neg[i][COORD_W-1:0]
                                             : r_s1_e[i][COORD_W-1:0];
        end
        n_s3_vraw = 53'(r_s2_prod[0]) + 53'(r_s2_prod[1]) + 53'(r_s2_prod[2]);
        n_s3_eo   = (r_s2_sq[0] >> FRAC_BITS) + (r_s2_sq[1] >> FRAC_BITS)
                  + (r_s2_sq[2] >> FRAC_BITS);
        n_s5_disc = {35'd0, r_s4_rsq} - {2'd0, r_s4_eo} + {2'd0, (r_s4_v2 >> FRAC_BITS)};
        n_s6_x    = r_s5_disc[63:0] << FRAC_BITS;
        n_s6_cand = r_s5_vok && !r_s5_disc[65] && (r_s5_disc != 66'd0)
                 && ((r_s5_disc >> (64 - FRAC_BITS)) == 66'd0) && (n_s6_x < r_s5_v2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= s_axis_tvalid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_g    <= w_g;
            r_s1_rsq  <= w_rsq;
            r_s1_best <= w_best;
            for (int i = 0; i < 3; i++) begin
                r_s1_e[i]    <= n_s1_e[i];
                r_s2_prod[i] <= $signed(r_s1_e[i]) * $signed(r_s1_g.d[i]);
                r_s2_sq[i]   <= 64'(n_s2_mag[i]) * 64'(n_s2_mag[i]);
            end
            r_s2_g    <= r_s1_g;
            r_s2_rsq  <= r_s1_rsq;
            r_s2_best <= r_s1_best;

            r_s3_proj <= n_s3_vraw >>> FRAC_BITS;
            r_s3_eo   <= n_s3_eo;
            r_s3_g    <= r_s2_g;
            r_s3_rsq  <= r_s2_rsq;
            r_s3_best <= r_s2_best;

            r_s4_vok  <= !r_s3_proj[52] && (r_s3_proj[52:32] == 21'd0)
                      && (r_s3_proj[31:0] != 32'd0);
            r_s4_vu   <= r_s3_proj[31:0];
            r_s4_v2   <= 64'(r_s3_proj[31:0]) * 64'(r_s3_proj[31:0]);
            r_s4_eo   <= r_s3_eo;
            r_s4_g    <= r_s3_g;
            r_s4_rsq  <= r_s3_rsq;
            r_s4_best <= r_s3_best;

            r_s5_disc <= n_s5_disc;
            r_s5_vok  <= r_s4_vok;
            r_s5_vu   <= r_s4_vu;
            r_s5_v2   <= r_s4_v2;
            r_s5_g    <= r_s4_g;
            r_s5_best <= r_s4_best;

            r_s6_x    <= n_s6_x;
            r_s6_cand <= n_s6_cand;
            r_s6_vu   <= r_s5_vu;
            r_s6_g    <= r_s5_g;
            r_s6_best <= r_s5_best;
        end
    end

    // discriminant root
    t_sq1               w_sq1_in, w_sq1_out;
    logic [SQ1_W-1:0]   w_sq1_bits;
    logic               w_sq1_v;
    logic [31:0]        w_root1;

    always_comb begin
        w_sq1_in.cand = r_s6_cand;
        w_sq1_in.vu   = r_s6_vu;
        w_sq1_in.g    = r_s6_g;
        w_sq1_in.best = r_s6_best;
    end

    rsch_isqrt #(.IN_W(64), .PAY_W(SQ1_W)) u_sqrt_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_v),
        .i_rad   (r_s6_x),
        .i_pay   (w_sq1_in),
        .o_valid (w_sq1_v),
        .o_root  (w_root1),
        .o_pay   (w_sq1_bits)
    );
    assign w_sq1_out = t_sq1'(w_sq1_bits);

    // hit decision, point, length
    logic                r_s7_v, r_s8_v, r_s9_v, r_s10_v, r_s11_v, r_s12_v, r_s13_v;
    logic                r_s7_hit, r_s8_hit, r_s9_hit, r_s10_hit, r_s11_hit, r_s12_hit;
    logic                r_s13_hit;
    logic [DIST_W-1:0]   r_s7_dist, r_s8_dist, r_s9_dist, r_s10_dist, r_s11_dist;
    logic [DIST_W-1:0]   r_s12_dist, r_s13_dist;
    t_geom               r_s7_g, r_s8_g;
    logic [COORD_W-1:0]  r_s9_c [3];
    logic signed [49:0]  r_s8_pr [3];
    logic [COORD_W-1:0]  r_s9_pt [3], r_s10_pt [3], r_s11_pt [3], r_s12_pt [3], r_s13_pt [3];
    logic [COORD_W:0]    r_s10_p [3];
    logic [MAG_W-1:0]    r_s11_m [3], r_s12_m [3], r_s13_m [3];
    logic [2:0]          r_s11_sgn, r_s12_sgn, r_s13_sgn;
    logic [61:0]         r_s12_sq [3];
    logic [63:0]         r_s13_len2;

    logic [COORD_W:0]    n_s7_t;
    logic                n_s7_hit;
    logic signed [50:0]  n_s9_s [3];
    logic [COORD_W-1:0]  n_s9_pt [3];
    logic [COORD_W:0]    n_s11_neg [3];
    logic [COORD_W-1:0]  n_s11_mag [3];
    logic                n_s11_big;

    always_comb begin
        n_s7_t   = {1'b0, w_sq1_out.vu} - {1'b0, w_root1};
        n_s7_hit = w_sq1_out.cand && !n_s7_t[COORD_W] && (n_s7_t != '0)
                && (n_s7_t[COORD_W-1:0] < {1'b0, w_sq1_out.best});
        for (int i = 0; i < 3; i++) begin
            n_s9_s[i] = 51'($signed(r_s8_g.o[i])) + 51'(r_s8_pr[i] >>> FRAC_BITS);
            if (n_s9_s[i] > 51'sh7FFF_FFFF) begin
                n_s9_pt[i] = 32'h7FFF_FFFF;
            end else if (n_s9_s[i] < -51'sh8000_0000) begin
                n_s9_pt[i] = 32'h8000_0000;
            end else begin
                n_s9_pt[i] = n_s9_s[i][31:0];
            end
            n_s11_neg[i] = (COORD_W + 1)'(0) - r_s10_p[i];
            n_s11_mag[i] = r_s10_p[i][COORD_W] ? n_s11_neg[i][COORD_W-1:0]
                                               : r_s10_p[i][COORD_W-1:0];
        end
        n_s11_big = n_s11_mag[0][31] | n_s11_mag[1][31] | n_s11_mag[2][31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_s9_v  <= 1'b0;
            r_s10_v <= 1'b0;
            r_s11_v <= 1'b0;
            r_s12_v <= 1'b0;
            r_s13_v <= 1'b0;
        end else if (en) begin
            r_s7_v  <= w_sq1_v;
            r_s8_v  <= r_s7_v;
            r_s9_v  <= r_s8_v;
            r_s10_v <= r_s9_v;
            r_s11_v <= r_s10_v;
            r_s12_v <= r_s11_v;
            r_s13_v <= r_s12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_hit  <= n_s7_hit;
            r_s7_dist <= n_s7_hit ? n_s7_t[DIST_W-1:0] : w_sq1_out.best;
            r_s7_g    <= w_sq1_out.g;

            r_s8_hit  <= r_s7_hit;
            r_s8_dist <= r_s7_dist;
            r_s8_g    <= r_s7_g;

            r_s9_hit  <= r_s8_hit;
            r_s9_dist <= r_s8_dist;

            r_s10_hit  <= r_s9_hit;
            r_s10_dist <= r_s9_dist;
            r_s11_hit  <= r_s10_hit;
            r_s11_dist <= r_s10_dist;
            r_s12_hit  <= r_s11_hit;
            r_s12_dist <= r_s11_dist;
            r_s13_hit  <= r_s12_hit;
            r_s13_dist <= r_s12_dist;

            for (int i = 0; i < 3; i++) begin
                r_s8_pr[i]  <= $signed(r_s7_g.d[i]) * $signed({1'b0, r_s7_dist});
                r_s9_pt[i]  <= n_s9_pt[i];
                r_s9_c[i]   <= r_s8_g.c[i];
                r_s10_p[i]  <= {r_s9_pt[i][COORD_W-1], r_s9_pt[i]}
                             - {r_s9_c[i][COORD_W-1], r_s9_c[i]};
                r_s10_pt[i] <= r_s9_pt[i];
                r_s11_m[i]  <= n_s11_big ? n_s11_mag[i][COORD_W-1:1]
                                         : n_s11_mag[i][MAG_W-1:0];
                r_s11_sgn[i] <= r_s10_p[i][COORD_W];
                r_s11_pt[i] <= r_s10_pt[i];
                r_s12_sq[i] <= 62'(r_s11_m[i]) * 62'(r_s11_m[i]);
                r_s12_m[i]  <= r_s11_m[i];
                r_s12_pt[i] <= r_s11_pt[i];
                r_s13_m[i]  <= r_s12_m[i];
                r_s13_pt[i] <= r_s12_pt[i];
            end
            r_s12_sgn  <= r_s11_sgn;
            r_s13_sgn  <= r_s12_sgn;
            r_s13_len2 <= 64'(r_s12_sq[0]) + 64'(r_s12_sq[1]) + 64'(r_s12_sq[2]);
        end
    end

    // length root
    t_sq2               w_sq2_in, w_sq2_out;
    logic [SQ2_W-1:0]   w_sq2_bits;
    logic               w_sq2_v;
    logic [31:0]        w_root2;

    always_comb begin
        w_sq2_in.hit    = r_s13_hit;
        w_sq2_in.near_t = r_s13_dist;
        w_sq2_in.sgn    = r_s13_sgn;
        for (int i = 0; i < 3; i++) begin
            w_sq2_in.pt[i] = r_s13_pt[i];
            w_sq2_in.m[i]  = r_s13_m[i];
        end
    end

    rsch_isqrt #(.IN_W(64), .PAY_W(SQ2_W)) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s13_v),
        .i_rad   (r_s13_len2),
        .i_pay   (w_sq2_in),
        .o_valid (w_sq2_v),
        .o_root  (w_root2),
        .o_pay   (w_sq2_bits)
    );
    assign w_sq2_out = t_sq2'(w_sq2_bits);

    // normal division
    t_dvp                     w_dv_in, w_dv_out;
    logic [DVP_W-1:0]         w_dv_bits;
    logic                     w_dv_v;
    logic [2:0][FRAC_BITS:0]  w_q;

    always_comb begin
        w_dv_in.hit    = w_sq2_out.hit;
        w_dv_in.near_t = w_sq2_out.near_t;
        w_dv_in.pt     = w_sq2_out.pt;
        w_dv_in.sgn    = w_sq2_out.sgn;
        w_dv_in.lz     = (w_root2 == 32'd0);
    end

    rsch_ndiv #(.FRAC_BITS(FRAC_BITS), .PAY_W(DVP_W)) u_ndiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_sq2_v),
        .i_m     (w_sq2_out.m),
        .i_den   (w_root2),
        .i_pay   (w_dv_in),
        .o_valid (w_dv_v),
        .o_q     (w_q),
        .o_pay   (w_dv_bits)
    );
    assign w_dv_out = t_dvp'(w_dv_bits);

    // result assembly
    logic [NORM_MAG_W-1:0]    n_fin_mag [3];
    logic [NORM_W-1:0]        n_fin_nrm [3];
    logic [2:0][COORD_W-1:0]  n_fin_pt;
    logic [OUT_FIELDS_W-1:0]  n_fin_data;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_fin_mag[i] = (64'(w_q[i]) > 64'(NORM_SAT)) ? NORM_MAG_W'(NORM_SAT)
                                                         : NORM_MAG_W'(w_q[i]);
            n_fin_nrm[i] = w_dv_out.sgn[i] ? (NORM_W'(0) - {1'b0, n_fin_mag[i]})
                                           : {1'b0, n_fin_mag[i]};
            if (w_dv_out.lz) begin
                n_fin_nrm[i] = (i == 2) ? {1'b0, DEG_Z} : '0;
            end
            if (!w_dv_out.hit) begin
                n_fin_nrm[i] = '0;
            end
        end
        n_fin_pt   = w_dv_out.hit ? w_dv_out.pt : '0;
        n_fin_data = {n_fin_nrm[2], n_fin_nrm[1], n_fin_nrm[0],
                      n_fin_pt[2], n_fin_pt[1], n_fin_pt[0], w_dv_out.near_t};
    end

    // output register and skid
    logic                     r_out_v;
    logic                     r_out_hit, r_skd_hit;
    logic [OUT_FIELDS_W-1:0]  r_out_data, r_skd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            if (r_skd_v) begin
                r_out_v <= 1'b1;
                r_skd_v <= 1'b0;
            end else begin
                r_out_v <= w_dv_v;
            end
        end else if (w_dv_v && en) begin
            r_skd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || m_axis_tready) begin
            if (r_skd_v) begin
                r_out_data <= r_skd_data;
                r_out_hit  <= r_skd_hit;
            end else begin
                r_out_data <= n_fin_data;
                r_out_hit  <= w_dv_out.hit;
            end
        end else if (en) begin
            r_skd_data <= n_fin_data;
            r_skd_hit  <= w_dv_out.hit;
        end
    end

    assign m_axis_tvalid   = r_out_v;
    assign m_axis_tdata    = OUT_TDATA_W'(r_out_data);
    assign m_axis_tuser[0] = r_out_hit;

    `RSCH_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skd_v, r_out_v, "skid full with output empty")
    `RSCH_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n, r_skd_v && !m_axis_tready, r_skd_v, "skid item dropped while stalled")
    `RSCH_ASSERT_IMP(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skd_v), $past(r_out_v && !m_axis_tready), "skid filled without a stall")
    `RSCH_ASSERT_IMP(a_hit_dist_nonzero, i_clk, i_rst_n, r_out_v && r_out_hit, r_out_data[DIST_W-1:0] != '0, "hit with zero distance")

endmodule
